/* design/xtea_pkg.sv */
// Package: XTEA types, round count and key schedule constants.
`timescale 1ns / 1ps
package xtea_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int STAGE_COUNT = 2 * ROUND_COUNT;
    localparam logic [31:0] ROUND_DELTA = 32'h9e37_79b9;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 3'd4;

    typedef logic [3:0][31:0] key_t;

    typedef struct packed {
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic        last_block;
    } block_in_t;

    typedef struct packed {
        logic [31:0] first_result;
        logic [31:0] second_result;
        logic        last_result;
    } block_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] v0;
        logic [31:0] v1;
        logic        last;
    } stage_t;

    function automatic logic [31:0] stage_sum(input int count);
        logic [63:0] full;
        full = 64'(count) * {32'd0, ROUND_DELTA};
        return full[31:0];
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

/* design/xtea_block_cipher.sv */
// Top level: XTEA ECB cipher as a chain of half-round cells with key and mode registers.
// Start travels with its block through the registered cells, one cell per half-round, to result_valid.
// Throughput: one block per cycle; busy is never raised, every cell advances each cycle.
// Results show for one cycle on result with result_valid; the receiver cannot stall.
// Reset: clears the pipeline valid bits, the key words and the mode (encrypt).
// cfg_ready is always high; a transfer to an index beyond decrypt_mode is dropped.
`timescale 1ns / 1ps
module xtea_block_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  xtea_pkg::block_in_t                  block_in,
    output logic                                 result_valid,
    output xtea_pkg::block_out_t                 result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);

    xtea_pkg::key_t    key_reg;
    xtea_pkg::key_t    key_next;
    logic              decrypt_reg;
    logic              decrypt_next;
    xtea_pkg::stage_t  chain [0:xtea_pkg::STAGE_COUNT];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next     = key_reg;
        decrypt_next = decrypt_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                xtea_pkg::REG_KEY_WORD_0:   key_next[0]  = cfg_data;
                xtea_pkg::REG_KEY_WORD_1:   key_next[1]  = cfg_data;
                xtea_pkg::REG_KEY_WORD_2:   key_next[2]  = cfg_data;
                xtea_pkg::REG_KEY_WORD_3:   key_next[3]  = cfg_data;
                xtea_pkg::REG_DECRYPT_MODE: decrypt_next = cfg_data[0];
                default:
                begin
                    key_next     = key_reg;
                    decrypt_next = decrypt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            decrypt_reg <= 1'b0;
        end
        else
        begin
            key_reg     <= key_next;
            decrypt_reg <= decrypt_next;
        end
    end

    assign chain[0] = {start, block_in.first_word, block_in.second_word, block_in.last_block};

    for (genvar i = 0; i < xtea_pkg::STAGE_COUNT; i++)
    begin : g_cell
        localparam int RND = i / 2;
        localparam int ODD = i % 2;
        localparam logic [31:0] ENC_SUM = xtea_pkg::stage_sum(RND + ODD);
        localparam logic [31:0] DEC_SUM =
            xtea_pkg::stage_sum(xtea_pkg::ROUND_COUNT - RND - ODD);

        xtea_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .decrypt   (decrypt_reg),
            .odd_stage (1'(ODD)),
            .enc_sum   (ENC_SUM),
            .dec_sum   (DEC_SUM),
            .key       (key_reg),
            .prev      (chain[i]),
            .curr      (chain[i+1])
        );
    end

    always_comb
    begin
        result_valid         = chain[xtea_pkg::STAGE_COUNT].valid;
        result.first_result  = chain[xtea_pkg::STAGE_COUNT].v0;
        result.second_result = chain[xtea_pkg::STAGE_COUNT].v1;
        result.last_result   = chain[xtea_pkg::STAGE_COUNT].last;
    end

endmodule

/* design/xtea_cell.sv */
// Cell: one XTEA half-round on a 64-bit block, registered toward the next cell.
`timescale 1ns / 1ps
module xtea_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                decrypt,
    input  logic                odd_stage,
    input  logic [31:0]         enc_sum,
    input  logic [31:0]         dec_sum,
    input  xtea_pkg::key_t      key,
    input  xtea_pkg::stage_t    prev,
    output xtea_pkg::stage_t    curr
);

    logic              upd_v1;
    logic [31:0]       sum;
    logic [1:0]        key_idx;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [31:0]       term;
    logic [31:0]       dst_new;
    logic              valid_reg;
    logic              valid_next;
    xtea_pkg::stage_t  data_reg;
    xtea_pkg::stage_t  data_next;

    always_comb
    begin
        upd_v1  = odd_stage ^ decrypt;
        sum     = decrypt ? dec_sum : enc_sum;
        key_idx = upd_v1 ? sum[12:11] : sum[1:0];
        src     = upd_v1 ? prev.v0 : prev.v1;
        dst     = upd_v1 ? prev.v1 : prev.v0;
        term    = xtea_pkg::mix(src) ^ (sum + key[key_idx]);
        dst_new = decrypt ? (dst - term) : (dst + term);
        data_next       = prev;
        data_next.valid = 1'b0;
        if (upd_v1)
        begin
            data_next.v1 = dst_new;
        end
        else
        begin
            data_next.v0 = dst_new;
        end
        valid_next = prev.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        curr       = data_reg;
        curr.valid = valid_reg;
    end

endmodule

/* tb/tb.sv */
// Testbench: XTEA block cipher stream checked against a round-by-round predictor.
`timescale 1ns / 1ps
module tb;

    localparam int INDEX_W = xtea_pkg::CFG_INDEX_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = xtea_pkg::STAGE_COUNT + 16;
    localparam logic [INDEX_W-1:0] REG_FIRST_UNUSED = xtea_pkg::REG_DECRYPT_MODE + 1'b1;
    localparam logic [INDEX_W-1:0] REG_LAST_UNUSED = '1;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    class xtea_scoreboard;
        logic [31:0]          key_word [4];
        logic                 decrypt;
        xtea_pkg::block_out_t expected_blocks [$];
        int                   errors;

        function new();
            foreach (key_word[i])
                key_word[i] = '0;
            decrypt = 1'b0;
            errors = 0;
        endfunction

        function void write_register(logic [INDEX_W-1:0] index, logic [31:0] data);
            case (index)
                xtea_pkg::REG_KEY_WORD_0: key_word[0] = data;
                xtea_pkg::REG_KEY_WORD_1: key_word[1] = data;
                xtea_pkg::REG_KEY_WORD_2: key_word[2] = data;
                xtea_pkg::REG_KEY_WORD_3: key_word[3] = data;
                xtea_pkg::REG_DECRYPT_MODE: decrypt = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] mix_word(logic [31:0] v);
            return ((v << 4) ^ (v >> 5)) + v;
        endfunction

        function xtea_pkg::block_out_t cipher_block(xtea_pkg::block_in_t blk);
            logic [31:0]          v0;
            logic [31:0]          v1;
            logic [31:0]          sum;
            xtea_pkg::block_out_t out_blk;
            v0 = blk.first_word;
            v1 = blk.second_word;
            if (!decrypt)
            begin
                sum = '0;
                for (int r = 0; r < xtea_pkg::ROUND_COUNT; r++)
                begin
                    v0 += mix_word(v1) ^ (sum + key_word[sum[1:0]]);
                    sum += xtea_pkg::ROUND_DELTA;
                    v1 += mix_word(v0) ^ (sum + key_word[sum[12:11]]);
                end
            end
            else
            begin
                sum = xtea_pkg::ROUND_DELTA * 32'(xtea_pkg::ROUND_COUNT);
                for (int r = 0; r < xtea_pkg::ROUND_COUNT; r++)
                begin
                    v1 -= mix_word(v0) ^ (sum + key_word[sum[12:11]]);
                    sum -= xtea_pkg::ROUND_DELTA;
                    v0 -= mix_word(v1) ^ (sum + key_word[sum[1:0]]);
                end
            end
            out_blk.first_result = v0;
            out_blk.second_result = v1;
            out_blk.last_result = blk.last_block;
            return out_blk;
        endfunction

        function void note_block(xtea_pkg::block_in_t blk);
            expected_blocks.push_back(cipher_block(blk));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(xtea_pkg::block_out_t got);
            xtea_pkg::block_out_t want;
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_blocks.pop_front();
            compare_field("first_result", want.first_result, got.first_result);
            compare_field("second_result", want.second_result, got.second_result);
            compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    xtea_pkg::block_in_t    block_in;
    logic                   result_valid;
    xtea_pkg::block_out_t   result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [INDEX_W-1:0]     cfg_index;
    logic [31:0]            cfg_data;

    xtea_scoreboard board;
    int             idle_pct;
    int             cycles = 0;

    xtea_block_cipher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block_in     (block_in),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** xtea_block_cipher: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(result);
    end

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [31:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_register(index, data);
        @(negedge clk);
    endtask

    task automatic program_cipher(input logic [31:0] k0, input logic [31:0] k1,
                                  input logic [31:0] k2, input logic [31:0] k3,
                                  input logic mode);
        write_reg(INDEX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)), $urandom());
        write_reg(xtea_pkg::REG_KEY_WORD_0, k0);
        write_reg(xtea_pkg::REG_KEY_WORD_1, k1);
        write_reg(xtea_pkg::REG_KEY_WORD_2, k2);
        write_reg(xtea_pkg::REG_KEY_WORD_3, k3);
        write_reg(xtea_pkg::REG_DECRYPT_MODE, {31'($urandom()), mode});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input xtea_pkg::block_in_t blk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        block_in <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_block(blk);
        @(negedge clk);
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (board.expected_blocks.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_corners();
        send_block('{32'h0, 32'h0, 1'b0});
        send_block('{ALL_ONES, ALL_ONES, 1'b1});
        send_block('{32'h0, ALL_ONES, 1'b1});
        send_block('{ALL_ONES, 32'h0, 1'b0});
        send_block('{32'h0000_0001, 32'h8000_0000, 1'b0});
        drain_all();
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return ALL_ONES;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_block('{pick_word(), pick_word(), 1'($urandom())});
        drain_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        block_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        board = new();
        idle_pct = 18;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_corners();
        program_cipher(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
        send_corners();
        program_cipher(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        send_corners();
        program_cipher(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_corners();

        for (int p = 0; p < 6; p++)
        begin
            idle_pct = (p == 2) ? 0 : 18;
            program_cipher(pick_word(), pick_word(), pick_word(), pick_word(), 1'(p));
            send_random(72);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.errors == 0)
            $display("** xtea_block_cipher: PASSED **");
        else
            $display("** xtea_block_cipher: FAILED **");
        $finish;
    end
endmodule
